FILE: hw/rtl/multi_queue_priority_process_table_macros.svh
// Assertion macros for the multi-queue priority process table.
// Included by the RTL modules that carry concurrent checks; uses clk and rst_n in scope.
`ifndef MULTI_QUEUE_PRIORITY_PROCESS_TABLE_MACROS_SVH
`define MULTI_QUEUE_PRIORITY_PROCESS_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mqpt_pkg.sv
// Shared types and constants for the multi-queue priority process table.
// No dependencies; used by mqpt_seq and the top level.
package mqpt_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_BAD_PRIO  = 3'd4;
  localparam logic [2:0] STATUS_EMPTY     = 3'd5;

  localparam logic signed [8:0] PRIO_MIN = -9'sd127;
  localparam logic signed [8:0] PRIO_MAX = 9'sd128;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        proc_id;
    logic signed [8:0] priority_req;
    logic [2:0]        queue_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        out_id;
    logic signed [8:0] out_priority;
    logic [2:0]        out_queue;
  } result_t;

endpackage

FILE: hw/rtl/multi_queue_priority_process_table.sv
// A peek, a find, a rejected insert or a remove of a missing id walks the slots once before
// its result can be taken on the output; a successful insert or remove walks them a second
// time, and a successful insert then writes the new entry.
// One transaction at a time: the next input is accepted only after the result has moved to
// the output register, and the slot walks go through the store's one read port.
// Reset (rst_n, synchronous, active low) empties every queue; slot contents stay unwritten.
module multi_queue_priority_process_table #(
  parameter int NUM_QUEUES = 8,
  parameter int CAPACITY   = 32,
  parameter int ID_BITS    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, low bit up: op[1:0], proc_id[9:2], priority_req[18:10],
  // queue_sel[21:19], zero fill[23:22].
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mqpt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata, low bit up: status[2:0], out_id[10:3], out_priority[19:11],
  // out_queue[22:20], zero fill[23].
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mqpt_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // The table keeps every process entry in one slot store. Each slot holds the
  // id, the priority, the queue number and the rank of the entry within its
  // queue (rank zero is the head). Every operation walks all slots once; an
  // insert or remove that succeeds walks them a second time to shift the ranks
  // of the entries behind the affected position, with the writes trailing the
  // reads by one slot. A successful insert then writes the new entry into the
  // lowest free slot.

  localparam logic [4:0] NQ = 5'(NUM_QUEUES);

  // Queue numbers at or above NUM_QUEUES wrap around by repeated subtraction.
  function automatic logic [2:0] queue_norm(input logic [2:0] v);
    logic [4:0] t;
    t = {2'b00, v};
    for (int k = 0; k < 7; k++) begin
      if (t >= NQ) begin
        t = t - NQ;
      end
    end
    return t[2:0];
  endfunction

  mqpt_pkg::cmd_t    cmd;
  mqpt_pkg::result_t res;
  mqpt_pkg::result_t out_res_r;
  logic              out_tvalid_r;
  logic              res_valid;
  logic              res_ready;

  assign cmd.op           = in_tdata[1:0];
  assign cmd.proc_id      = in_tdata[9:2];
  assign cmd.priority_req = $signed(in_tdata[18:10]);
  assign cmd.queue_sel    = queue_norm(in_tdata[21:19]);

  mqpt_seq #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: a finished result waits here while the sequencer goes
  // back to idle and takes the next input transaction.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
      out_res_r    <= res;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_res_r.out_queue, out_res_r.out_priority,
                       out_res_r.out_id, out_res_r.status};

endmodule

FILE: hw/rtl/mqpt_seq.sv
// Operation sequencer and slot store of the multi-queue priority process table.
// Depends on mqpt_pkg and multi_queue_priority_process_table_macros.svh.
`include "multi_queue_priority_process_table_macros.svh"

module mqpt_seq #(
  parameter int CAPACITY = 32,
  parameter int ID_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  mqpt_pkg::cmd_t   cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output mqpt_pkg::result_t res
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = AW + 1;
  localparam int RW  = AW;
  localparam int PW  = 9;
  localparam int QW  = 3;
  localparam int WW  = ID_BITS + PW + QW + RW;
  localparam int IXW = (ID_BITS > 8) ? ID_BITS : 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIX   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  function automatic logic [7:0] id_to_port(input logic [ID_BITS-1:0] v);
    logic [IXW-1:0] t;
    t = IXW'(v);
    return t[7:0];
  endfunction

  // Slot store: one word per slot, {id, priority, queue, rank}.
  logic [WW-1:0] mem [CAPACITY];
  logic [WW-1:0] rd_data_r;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [WW-1:0] mem_wr_data;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          op_r;
  logic [ID_BITS-1:0]  id_r;
  logic signed [8:0]   prio_r;
  logic [QW-1:0]       q_r;
  logic [CW-1:0]       idx_r;
  logic                rv_r;
  logic [AW-1:0]       ridx_r;
  logic [CAPACITY-1:0] valid_r;
  logic                mfound_r;
  logic [AW-1:0]       mslot_r;
  logic [QW-1:0]       mq_r;
  logic [RW-1:0]       mrank_r;
  logic signed [8:0]   mprio_r;
  logic                ffound_r;
  logic [AW-1:0]       fslot_r;
  logic [RW-1:0]       pos_r;
  logic                hfound_r;
  logic [ID_BITS-1:0]  hid_r;
  logic signed [8:0]   hprio_r;
  mqpt_pkg::result_t   res_r, dec_res;

  logic [IXW-1:0]     id_in_ext;
  logic [ID_BITS-1:0] id_in;
  logic               issue, scan_done, vld_d, bad_prio, fix_hit;
  logic [ID_BITS-1:0] d_id;
  logic signed [8:0]  d_prio;
  logic [QW-1:0]      d_q, fix_q;
  logic [RW-1:0]      d_rank, new_rank;

  assign id_in_ext = IXW'(cmd.proc_id);
  assign id_in     = id_in_ext[ID_BITS-1:0];

  assign d_rank = rd_data_r[RW-1:0];
  assign d_q    = rd_data_r[RW+QW-1:RW];
  assign d_prio = $signed(rd_data_r[RW+QW+PW-1:RW+QW]);
  assign d_id   = rd_data_r[WW-1:RW+QW+PW];
  assign vld_d  = valid_r[ridx_r];

  // Both passes walk every slot: one read issued per cycle, its data returned through rd_data_r.
  assign issue     = ((state_r == S_SCAN) || (state_r == S_FIX)) && (idx_r < CW'(CAPACITY));
  assign scan_done = !issue && !rv_r;
  assign bad_prio  = (prio_r < mqpt_pkg::PRIO_MIN) || (prio_r > mqpt_pkg::PRIO_MAX);

  // Rank fix-up: insert pushes down ranks at or after the new position,
  // remove pulls up ranks behind the removed entry.
  assign fix_q    = (op_r == mqpt_pkg::OP_INSERT) ? q_r : mq_r;
  assign fix_hit  = rv_r && vld_d && (d_q == fix_q) &&
                    ((op_r == mqpt_pkg::OP_INSERT) ? (d_rank >= pos_r) : (d_rank > mrank_r));
  assign new_rank = (op_r == mqpt_pkg::OP_INSERT) ? (d_rank + RW'(1)) : (d_rank - RW'(1));

  assign mem_rd_en   = issue;
  assign mem_rd_addr = idx_r[AW-1:0];

  // The write trails the read by one slot, so the two ports never meet on one entry.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = ridx_r;
    mem_wr_data = {d_id, d_prio, d_q, new_rank};
    if ((state_r == S_FIX) && fix_hit) begin
      mem_wr_en = 1'b1;
    end else if (state_r == S_WRITE) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = fslot_r;
      mem_wr_data = {id_r, prio_r, q_r, pos_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= mem[mem_rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    dec_res   = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_DONE;
          case (op_r)
            mqpt_pkg::OP_INSERT: begin
              if (mfound_r) begin
                dec_res.status = mqpt_pkg::STATUS_DUPLICATE;
              end else if (bad_prio) begin
                dec_res.status = mqpt_pkg::STATUS_BAD_PRIO;
              end else if (!ffound_r) begin
                dec_res.status = mqpt_pkg::STATUS_FULL;
              end else begin
                state_nxt = S_FIX;
              end
            end
            mqpt_pkg::OP_REMOVE: begin
              if (!mfound_r) begin
                dec_res.status = mqpt_pkg::STATUS_NOT_FOUND;
              end else begin
                state_nxt = S_FIX;
              end
            end
            mqpt_pkg::OP_PEEK: begin
              if (hfound_r) begin
                dec_res.out_id       = id_to_port(hid_r);
                dec_res.out_priority = hprio_r;
                dec_res.out_queue    = q_r;
              end else begin
                dec_res.status = mqpt_pkg::STATUS_EMPTY;
              end
            end
            mqpt_pkg::OP_FIND: begin
              if (mfound_r) begin
                dec_res.out_id       = id_to_port(id_r);
                dec_res.out_priority = mprio_r;
                dec_res.out_queue    = mq_r;
              end else begin
                dec_res.status = mqpt_pkg::STATUS_NOT_FOUND;
              end
            end
            default: begin
              dec_res.status = mqpt_pkg::STATUS_NOT_FOUND;
            end
          endcase
        end
      end
      S_FIX: begin
        if (scan_done) begin
          state_nxt = (op_r == mqpt_pkg::OP_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r    <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= issue;
      ridx_r  <= idx_r[AW-1:0];
      if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            op_r     <= cmd.op;
            id_r     <= id_in;
            prio_r   <= cmd.priority_req;
            q_r      <= cmd.queue_sel;
            idx_r    <= '0;
            mfound_r <= 1'b0;
            ffound_r <= 1'b0;
            hfound_r <= 1'b0;
            pos_r    <= '0;
          end
        end
        S_SCAN: begin
          if (rv_r) begin
            if (vld_d && (d_id == id_r) && !mfound_r) begin
              mfound_r <= 1'b1;
              mslot_r  <= ridx_r;
              mq_r     <= d_q;
              mrank_r  <= d_rank;
              mprio_r  <= d_prio;
            end
            if (!vld_d && !ffound_r) begin
              ffound_r <= 1'b1;
              fslot_r  <= ridx_r;
            end
            if (vld_d && (d_q == q_r) && (d_prio >= prio_r)) begin
              pos_r <= pos_r + RW'(1);
            end
            if (vld_d && (d_q == q_r) && (d_rank == '0) && !hfound_r) begin
              hfound_r <= 1'b1;
              hid_r    <= d_id;
              hprio_r  <= d_prio;
            end
          end
          if (scan_done) begin
            idx_r <= '0;
            res_r <= dec_res;
            if ((op_r == mqpt_pkg::OP_REMOVE) && mfound_r) begin
              valid_r[mslot_r] <= 1'b0;
            end
          end
        end
        S_WRITE: begin
          valid_r[fslot_r] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  `MQPT_ASSERT_SAME(a_err_fields_zero, res_valid && (res.status != mqpt_pkg::STATUS_OK), (res.out_id == 8'd0) && (res.out_priority == 9'sd0) && (res.out_queue == 3'd0), "error result carries nonzero data")
  `MQPT_ASSERT_SAME(a_full_means_full, res_valid && (res.status == mqpt_pkg::STATUS_FULL), &valid_r, "full reported with a free slot")
  `MQPT_ASSERT_SAME(a_no_port_clash, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write hit the same slot")
  `MQPT_ASSERT_NEXT(a_insert_fills_one, state_r == S_WRITE, $countones(valid_r) == ($past($countones(valid_r)) + 1), "insert did not add exactly one entry")
  `MQPT_ASSERT_NEXT(a_remove_frees_one, (state_r == S_SCAN) && scan_done && (op_r == mqpt_pkg::OP_REMOVE) && mfound_r, $countones(valid_r) == ($past($countones(valid_r)) - 1), "remove did not free exactly one entry")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the multi-queue priority process table.
// Depends on mqpt_pkg and multi_queue_priority_process_table; drives stream traffic and
// checks every result transaction against a built-in prediction of the table contents.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_QUEUES = 8;
  localparam int CAPACITY   = 32;
  localparam int ID_BITS    = 8;

  // Number of random transactions after the directed part.
  localparam int RANDOM_ITEMS = 1700;
  // Cycles without any accepted transaction before the run is declared hung. The slowest
  // transaction is a successful insert, and the receiver can stall on top of it.
  localparam int IDLE_LIMIT = 3000;
  // Cycles to keep watching after the last result, longer than one insert takes.
  localparam int DRAIN_CYCLES = 100;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [mqpt_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [mqpt_pkg::OUT_TDATA_W-1:0] out_tdata;

  multi_queue_priority_process_table #(
    .NUM_QUEUES (NUM_QUEUES),
    .CAPACITY   (CAPACITY),
    .ID_BITS    (ID_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction of the table. Each slot of the shared store holds one process entry; its
  // position within its own queue is kept explicitly, with 0 meaning the head.
  // ---------------------------------------------------------------------------------------
  logic              entry_live  [CAPACITY];
  logic [7:0]        entry_id    [CAPACITY];
  logic signed [8:0] entry_prio  [CAPACITY];
  logic [2:0]        entry_queue [CAPACITY];
  int                entry_pos   [CAPACITY];

  // Results still owed by the block, oldest first.
  mqpt_pkg::result_t owed_results[$];
  int                mismatches;
  int                idle_cycles;

  function automatic int slot_of_id(logic [7:0] pid);
    for (int i = 0; i < CAPACITY; i++) begin
      if (entry_live[i] && entry_id[i] == pid) return i;
    end
    return -1;
  endfunction

  // Carries out one command on the predicted table and returns the result it must give.
  function automatic mqpt_pkg::result_t apply_table_op(mqpt_pkg::cmd_t c);
    mqpt_pkg::result_t r;
    int                hit;
    int                free_slot;
    int                pos;
    logic [2:0]        q;
    r   = '0;
    q   = 3'(c.queue_sel % NUM_QUEUES);
    hit = slot_of_id(c.proc_id);
    case (c.op)
      mqpt_pkg::OP_INSERT: begin
        // Duplicate id wins over bad priority, which wins over a full store.
        if (hit >= 0) begin
          r.status = mqpt_pkg::STATUS_DUPLICATE;
        end else if (c.priority_req < mqpt_pkg::PRIO_MIN ||
                     c.priority_req > mqpt_pkg::PRIO_MAX) begin
          r.status = mqpt_pkg::STATUS_BAD_PRIO;
        end else begin
          free_slot = -1;
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!entry_live[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            r.status = mqpt_pkg::STATUS_FULL;
          end else begin
            // The new entry goes behind every entry of equal or higher priority.
            pos = 0;
            for (int i = 0; i < CAPACITY; i++) begin
              if (entry_live[i] && entry_queue[i] == q && entry_prio[i] >= c.priority_req)
                pos++;
            end
            for (int i = 0; i < CAPACITY; i++) begin
              if (entry_live[i] && entry_queue[i] == q && entry_pos[i] >= pos)
                entry_pos[i]++;
            end
            entry_live[free_slot]  = 1'b1;
            entry_id[free_slot]    = c.proc_id;
            entry_prio[free_slot]  = c.priority_req;
            entry_queue[free_slot] = q;
            entry_pos[free_slot]   = pos;
            r.status = mqpt_pkg::STATUS_OK;
          end
        end
      end
      mqpt_pkg::OP_REMOVE: begin
        if (hit < 0) begin
          r.status = mqpt_pkg::STATUS_NOT_FOUND;
        end else begin
          entry_live[hit] = 1'b0;
          for (int i = 0; i < CAPACITY; i++) begin
            if (entry_live[i] && entry_queue[i] == entry_queue[hit] &&
                entry_pos[i] > entry_pos[hit])
              entry_pos[i]--;
          end
          r.status = mqpt_pkg::STATUS_OK;
        end
      end
      mqpt_pkg::OP_PEEK: begin
        r.status = mqpt_pkg::STATUS_EMPTY;
        for (int i = 0; i < CAPACITY; i++) begin
          if (entry_live[i] && entry_queue[i] == q && entry_pos[i] == 0) begin
            r.status       = mqpt_pkg::STATUS_OK;
            r.out_id       = entry_id[i];
            r.out_priority = entry_prio[i];
            r.out_queue    = entry_queue[i];
          end
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = mqpt_pkg::STATUS_NOT_FOUND;
        end else begin
          r.status       = mqpt_pkg::STATUS_OK;
          r.out_id       = entry_id[hit];
          r.out_priority = entry_prio[hit];
          r.out_queue    = entry_queue[hit];
        end
      end
    endcase
    return r;
  endfunction

  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 0; i < CAPACITY; i++) n += int'(entry_live[i]);
    return n;
  endfunction

  // Returns the id of a randomly chosen live entry, or a random id when the table is empty.
  function automatic logic [7:0] some_live_id();
    int k;
    int n;
    n = live_entries();
    if (n == 0) return 8'($urandom_range(0, 255));
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < CAPACITY; i++) begin
      if (entry_live[i]) begin
        if (k == 0) return entry_id[i];
        k--;
      end
    end
    return 8'd0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender. Inputs change on the falling edge. Commands go out in bursts of random length;
  // between bursts in_tvalid drops low. Within a burst in_tvalid stays high and only the
  // data changes, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------------------
  int burst_left;

  task automatic send_cmd(input mqpt_pkg::cmd_t c, input bit typed,
                          input mqpt_pkg::result_t typed_want);
    mqpt_pkg::result_t predicted;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // Now and then a long burst gives a stretch with no sender idling at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, c.queue_sel, c.priority_req, c.proc_id, c.op};
    // The transaction is taken at the first rising edge with in_tready high; in_tready is
    // read here before the block's own updates for that edge take effect.
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_table_op(c);
    // Rows with a hand-typed answer still run through the prediction so the table state
    // stays in step with the block.
    owed_results.push_back(typed ? typed_want : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver. It switches between stall styles: always ready, a rotating 8-bit
  // pattern, mostly ready at random, or mostly stalled.
  // ---------------------------------------------------------------------------------------
  int         stall_style;
  int         stall_phase;
  logic [7:0] stall_mask;

  initial begin
    stall_style = 0;
    stall_phase = 0;
    stall_mask  = 8'hff;
  end

  always @(negedge clk) begin
    if (stall_phase % 64 == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_mask  = 8'($urandom_range(0, 255));
    end
    case (stall_style)
      0:       out_tready = 1'b1;
      1:       out_tready = stall_mask[stall_phase % 8];
      2:       out_tready = ($urandom_range(0, 3) != 0);
      default: out_tready = ($urandom_range(0, 7) == 0);
    endcase
    stall_phase++;
  end

  // ---------------------------------------------------------------------------------------
  // Result checker: each result transaction is compared field by field with the oldest
  // owed result. Mismatch lines list status/id/priority/queue.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    mqpt_pkg::result_t got;
    mqpt_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status       = out_tdata[2:0];
      got.out_id       = out_tdata[10:3];
      got.out_priority = out_tdata[19:11];
      got.out_queue    = out_tdata[22:20];
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %0d id %0d prio %0d queue %0d",
                   $realtime, got.status, got.out_id, got.out_priority, got.out_queue);
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status || got.out_id !== want.out_id ||
            got.out_priority !== want.out_priority || got.out_queue !== want.out_queue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $realtime, want.status, want.out_id, want.out_priority, want.out_queue,
                     got.status, got.out_id, got.out_priority, got.out_queue);
        end
      end
    end
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Directed stimulus table. A row carries either a hand-typed status (the other fields are
  // then zero) or leaves the answer to the prediction.
  // ---------------------------------------------------------------------------------------
  typedef struct {
    mqpt_pkg::cmd_t cmd;
    bit             typed;
    logic [2:0]     status;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(input logic [1:0] op, input int pid, input int prio, input int q,
                         input bit typed, input logic [2:0] status);
    directed_row_t row;
    row.cmd.op           = op;
    row.cmd.proc_id      = 8'(pid);
    row.cmd.priority_req = 9'(prio);
    row.cmd.queue_sel    = 3'(q);
    row.typed            = typed;
    row.status           = status;
    directed_rows.push_back(row);
  endtask

  initial begin
    mqpt_pkg::cmd_t    c;
    mqpt_pkg::result_t want;
    int                mode;
    int                pick;
    int                v;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    burst_left  = 0;
    mismatches  = 0;
    idle_cycles = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      entry_live[i]  = 1'b0;
      entry_id[i]    = '0;
      entry_prio[i]  = '0;
      entry_queue[i] = '0;
      entry_pos[i]   = 0;
    end

    // Empty table: nothing to peek, find or remove.
    add_row(mqpt_pkg::OP_PEEK,     0,    0, 0, 1, mqpt_pkg::STATUS_EMPTY);
    add_row(mqpt_pkg::OP_PEEK,     0,    0, 7, 1, mqpt_pkg::STATUS_EMPTY);
    add_row(mqpt_pkg::OP_FIND,     0,    0, 0, 1, mqpt_pkg::STATUS_NOT_FOUND);
    add_row(mqpt_pkg::OP_REMOVE, 255,    0, 0, 1, mqpt_pkg::STATUS_NOT_FOUND);
    // -128 lies just below the accepted range of -127 to 128, so an insert refuses it.
    add_row(mqpt_pkg::OP_INSERT,   0, -128, 0, 1, mqpt_pkg::STATUS_BAD_PRIO);
    add_row(mqpt_pkg::OP_INSERT,  10,  128, 7, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_INSERT,  10,    5, 3, 1, mqpt_pkg::STATUS_DUPLICATE);
    // A duplicate id is reported even when the priority is also bad.
    add_row(mqpt_pkg::OP_INSERT,  10, -128, 3, 1, mqpt_pkg::STATUS_DUPLICATE);
    add_row(mqpt_pkg::OP_INSERT, 255, -127, 7, 1, mqpt_pkg::STATUS_OK);
    // Equal priority queues up behind the earlier entry.
    add_row(mqpt_pkg::OP_INSERT,   0,  128, 7, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_INSERT,  85,    0, 7, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_PEEK,     0,    0, 7, 0, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_FIND,   255,    0, 0, 0, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_FIND,     0,    0, 0, 0, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_REMOVE,  10,    0, 0, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_PEEK,     0,    0, 7, 0, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_REMOVE,  10,    0, 0, 1, mqpt_pkg::STATUS_NOT_FOUND);
    add_row(mqpt_pkg::OP_INSERT, 170,  128, 0, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_INSERT,   1,   -1, 0, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_PEEK,     0,    0, 0, 0, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_REMOVE, 170,    0, 0, 1, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_PEEK,     0,    0, 0, 0, mqpt_pkg::STATUS_OK);
    add_row(mqpt_pkg::OP_FIND,   170,    0, 0, 1, mqpt_pkg::STATUS_NOT_FOUND);

    // Synchronous reset, released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      want        = '0;
      want.status = directed_rows[k].status;
      send_cmd(directed_rows[k].cmd, directed_rows[k].typed, want);
    end

    // Fill the store to capacity across all queues, then probe the full-store checks:
    // a full store is reported only after the duplicate and priority checks pass.
    for (int i = 0; live_entries() < CAPACITY; i++) begin
      c.op           = mqpt_pkg::OP_INSERT;
      c.proc_id      = 8'(128 + i);
      c.priority_req = 9'((i % 5) * 40 - 80);
      c.queue_sel    = 3'(i % NUM_QUEUES);
      send_cmd(c, 1'b0, '0);
    end
    c = '{op: mqpt_pkg::OP_INSERT, proc_id: 8'd200, priority_req: 9'sd3,
          queue_sel: 3'd2};
    send_cmd(c, 1'b0, '0);
    c = '{op: mqpt_pkg::OP_INSERT, proc_id: 8'd201, priority_req: -9'sd128,
          queue_sel: 3'd2};
    send_cmd(c, 1'b0, '0);
    c = '{op: mqpt_pkg::OP_INSERT, proc_id: 8'd0, priority_req: 9'sd3,
          queue_sel: 3'd2};
    send_cmd(c, 1'b0, '0);
    for (int q = 0; q < NUM_QUEUES; q++) begin
      c = '{op: mqpt_pkg::OP_PEEK, proc_id: 8'd0, priority_req: 9'sd0,
            queue_sel: 3'(q)};
      send_cmd(c, 1'b0, '0);
    end

    // Random part. The mix of operations shifts every 60 transactions between filling,
    // draining and a balanced load, so the table swings between empty and full. Most ids
    // of removes and finds name live entries; priorities often repeat to exercise ties.
    mode = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      c    = '0;
      case (mode)
        0:       c.op = (pick < 60) ? mqpt_pkg::OP_INSERT : (pick < 70) ? mqpt_pkg::OP_REMOVE :
                        (pick < 85) ? mqpt_pkg::OP_PEEK : mqpt_pkg::OP_FIND;
        1:       c.op = (pick < 20) ? mqpt_pkg::OP_INSERT : (pick < 65) ? mqpt_pkg::OP_REMOVE :
                        (pick < 82) ? mqpt_pkg::OP_PEEK : mqpt_pkg::OP_FIND;
        default: c.op = (pick < 35) ? mqpt_pkg::OP_INSERT : (pick < 60) ? mqpt_pkg::OP_REMOVE :
                        (pick < 80) ? mqpt_pkg::OP_PEEK : mqpt_pkg::OP_FIND;
      endcase

      pick      = $urandom_range(0, 99);
      c.proc_id = (c.op == mqpt_pkg::OP_INSERT) ? ((pick < 20) ? some_live_id()
                                                               : 8'($urandom_range(0, 255)))
                                                : ((pick < 75) ? some_live_id()
                                                               : 8'($urandom_range(0, 255)));

      // Half the time only two queues are used so that they grow deep.
      c.queue_sel = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 1))
                                                : 3'($urandom_range(0, NUM_QUEUES - 1));

      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 6))
          0:       v = -127;
          1:       v = -5;
          2:       v = -1;
          3:       v = 0;
          4:       v = 1;
          5:       v = 5;
          default: v = 128;
        endcase
      end else if (pick < 95) begin
        v = int'($urandom_range(0, 255)) - 127;
      end else begin
        v = -128;
      end
      c.priority_req = v[8:0];

      send_cmd(c, 1'b0, '0);
    end
    in_tvalid = 1'b0;

    // Wait for every owed result, then watch a while longer for stray results.
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mqpt_pkg.sv
hw/rtl/mqpt_seq.sv
hw/rtl/multi_queue_priority_process_table.sv
tb/tb.sv
